@@ rtl/esdp_pkg.sv @@
// Shared types and constants for the element status descriptor parser.
// Holds the item structs, the parse phase and result kind codes, and the queue sizing.
// No dependencies.
package esdp_pkg;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PAGE   = 2'd1,
		PH_DESC   = 2'd2,
		PH_SKIP   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		RK_ELEMENT = 2'd0,
		RK_SUCCESS = 2'd1,
		RK_FAILURE = 2'd2
	} result_kind_t;

	localparam int HEADER_LAST = 7;
	localparam int DESC_BYTES  = 12;
	localparam logic [15:0] DESC_MIN = 16'd12;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [7:0]   elem_type;
		logic [15:0]  elem_addr;
		logic [5:0]   status_flags;
		logic [7:0]   sense_code;
		logic [7:0]   sense_qualifier;
		logic [2:0]   logical_unit;
		logic [2:0]   bus_flags;
		logic [7:0]   target_id;
		logic [1:0]   source_flags;
		logic [15:0]  source_address;
	} out_item_t;

	typedef struct packed {
		logic         has_elem;
		logic         has_verdict;
		result_kind_t verdict;
		out_item_t    elem;
	} esdp_evt_t;

endpackage

@@ rtl/element_status_descriptor_parser_top.sv @@
// Top level of the element status descriptor parser.
// A result passes through the event queue and then the output register before it is valid.
// Throughput: one byte per cycle while the event queue has room; a byte that yields an element
// and a verdict gives two items, which the four-entry queue between front and back end absorbs.
// Reset: arst_n clears all control state; the parser then expects a new response header.
// Depends on esdp_pkg, esdp_front, esdp_queue and esdp_back.
module element_status_descriptor_parser_top import esdp_pkg::*; #(
	parameter int POSITION_BITS = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  in_item_t  item,
	output logic      item_stall,
	output logic      result_valid,
	output out_item_t result,
	input  logic      result_stall
);

	esdp_evt_t evt, head;
	logic      push, pop, full, head_valid;

	esdp_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.full       (full),
		.item_stall (item_stall),
		.push       (push),
		.evt        (evt)
	);

	esdp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_evt     (evt),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	esdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

endmodule

@@ rtl/esdp_front.sv @@
// Front end of the parser: accepts response bytes, tracks headers, pages and descriptors.
// Pushes one event per byte that yields an element, a verdict or both.
// Depends on esdp_pkg.
module esdp_front import esdp_pkg::*; #(
	parameter int POSITION_BITS = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  in_item_t  item,
	input  logic      full,
	output logic      item_stall,
	output logic      push,
	output esdp_evt_t evt
);

	localparam int SW = ((POSITION_BITS > 24) ? POSITION_BITS : 24) + 1;
	localparam logic [POSITION_BITS-1:0] PMAX = '1;

	logic [POSITION_BITS-1:0] pos_q, eff_q, pend_q;
	logic [POSITION_BITS-1:0] pos_d, eff_d, pend_d;
	phase_t                   phase_q, phase_d, ph;
	logic [7:0]               ptype_q, ptype_d;
	logic [15:0]              dl_q, dl_d, k_q, k_d, kc;
	logic                     any_q, any_d;
	logic [7:0]               hb0_q, hb2_q, hb3_q, hb5_q, hb6_q;
	logic [7:0]               desc_q [DESC_BYTES];

	logic                     accept, sat, restart, emit, hdr_we, desc_we, last;
	logic [2:0]               hdr_idx;
	logic [7:0]               b, d11;
	logic [SW-1:0]            eff_sum, pe_sum;
	logic [POSITION_BITS-1:0] eff_cap, pend_new, eff_min;
	logic                     verdict_ok;

	assign item_stall = full;
	assign accept     = item_valid && !full;
	assign b          = item.data_byte;
	assign last       = item.end_of_buffer;
	assign sat        = (pos_q == PMAX);

	assign eff_sum  = SW'({hb5_q, hb6_q, b}) + SW'(8);
	assign eff_cap  = (eff_sum > SW'(PMAX)) ? PMAX : eff_sum[POSITION_BITS-1:0];
	assign pe_sum   = SW'(pos_q) + SW'(1) + SW'({hb5_q, hb6_q, b});
	assign pend_new = (pe_sum < SW'(eff_q)) ? pe_sum[POSITION_BITS-1:0] : eff_q;

	always_comb begin
		pos_d   = sat ? pos_q : pos_q + 1'b1;
		eff_d   = eff_q;
		pend_d  = pend_q;
		phase_d = phase_q;
		ptype_d = ptype_q;
		dl_d    = dl_q;
		k_d     = k_q;
		any_d   = any_q;
		hdr_we  = 1'b0;
		hdr_idx = 3'd0;
		desc_we = 1'b0;
		emit    = 1'b0;
		restart = 1'b0;
		ph      = phase_q;
		kc      = k_q;
		if (!sat) begin
			if (phase_q == PH_HEADER) begin
				hdr_we  = 1'b1;
				hdr_idx = pos_q[2:0];
				if (pos_q >= POSITION_BITS'(HEADER_LAST)) begin
					eff_d   = eff_cap;
					phase_d = PH_PAGE;
					k_d     = '0;
				end
			end else if (pos_q < eff_q) begin
				restart = (phase_q != PH_PAGE) && (pos_q >= pend_q);
				ph      = restart ? PH_PAGE : phase_q;
				kc      = restart ? '0 : k_q;
				case (ph)
					PH_PAGE: begin
						hdr_we  = 1'b1;
						hdr_idx = kc[2:0];
						if (kc >= 16'(HEADER_LAST)) begin
							ptype_d = hb0_q;
							dl_d    = {hb2_q, hb3_q};
							pend_d  = pend_new;
							k_d     = '0;
							phase_d = ({hb2_q, hb3_q} >= DESC_MIN) ? PH_DESC : PH_SKIP;
						end else begin
							k_d     = kc + 16'd1;
							phase_d = PH_PAGE;
						end
					end
					PH_DESC: begin
						desc_we = (kc < 16'(DESC_BYTES));
						phase_d = PH_DESC;
						if (kc + 16'd1 == dl_q) begin
							emit  = 1'b1;
							any_d = 1'b1;
							k_d   = '0;
						end else begin
							k_d = kc + 16'd1;
						end
					end
					PH_SKIP: begin
						phase_d = PH_SKIP;
						k_d     = kc + 16'd1;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
		eff_min    = (pos_d < eff_d) ? pos_d : eff_d;
		verdict_ok = (pos_d >= POSITION_BITS'(8)) &&
			(any_d || (eff_min == POSITION_BITS'(8)));
		if (last) begin
			pos_d   = '0;
			eff_d   = '0;
			pend_d  = '0;
			phase_d = PH_HEADER;
			ptype_d = '0;
			dl_d    = '0;
			k_d     = '0;
			any_d   = 1'b0;
		end
	end

	assign d11 = (kc == 16'(DESC_BYTES - 1)) ? b : desc_q[DESC_BYTES-1];

	always_comb begin
		push                     = accept && (emit || last);
		evt.has_elem             = emit;
		evt.has_verdict          = last;
		evt.verdict              = verdict_ok ? RK_SUCCESS : RK_FAILURE;
		evt.elem.result_kind     = RK_ELEMENT;
		evt.elem.elem_type       = ptype_q;
		evt.elem.elem_addr       = {desc_q[0], desc_q[1]};
		evt.elem.status_flags    = desc_q[2][5:0];
		evt.elem.sense_code      = desc_q[4];
		evt.elem.sense_qualifier = desc_q[5];
		evt.elem.logical_unit    = desc_q[6][2:0];
		evt.elem.bus_flags       = {desc_q[6][7], desc_q[6][5], desc_q[6][4]};
		evt.elem.target_id       = desc_q[7];
		evt.elem.source_flags    = {desc_q[9][7], desc_q[9][6]};
		evt.elem.source_address  = {desc_q[10], d11};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			eff_q   <= '0;
			pend_q  <= '0;
			phase_q <= PH_HEADER;
			ptype_q <= '0;
			dl_q    <= '0;
			k_q     <= '0;
			any_q   <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_d;
			eff_q   <= eff_d;
			pend_q  <= pend_d;
			phase_q <= phase_d;
			ptype_q <= ptype_d;
			dl_q    <= dl_d;
			k_q     <= k_d;
			any_q   <= any_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hdr_we) begin
			case (hdr_idx)
				3'd0: hb0_q <= b;
				3'd2: hb2_q <= b;
				3'd3: hb3_q <= b;
				3'd5: hb5_q <= b;
				3'd6: hb6_q <= b;
				default: ;
			endcase
		end
		if (accept && desc_we) begin
			desc_q[kc[3:0]] <= b;
		end
	end

	a_verdict_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && evt.has_verdict) |=> (pos_q == '0 && phase_q == PH_HEADER && !any_q))
		else $error("parser state not cleared after verdict");

	a_header_before_pages: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER) |-> (pos_q >= POSITION_BITS'(8)))
		else $error("page phase entered before response header complete");

	a_emit_in_descriptor: assert property (@(posedge clk) disable iff (!arst_n)
		(push && evt.has_elem) |-> (dl_q >= DESC_MIN && ph == PH_DESC))
		else $error("element emitted from a short descriptor");

endmodule

@@ rtl/esdp_queue.sv @@
// Short event queue between the parser front end and the result back end.
// Holds up to QUEUE_DEPTH events; head is shown combinationally, without a registered read.
// Depends on esdp_pkg.
module esdp_queue import esdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  esdp_evt_t wr_evt,
	input  logic      pop,
	output esdp_evt_t head,
	output logic      head_valid,
	output logic      full
);

	esdp_evt_t           mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_pop;

	assign head       = mem[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_ptr_q] <= wr_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("event pushed into a full queue");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

@@ rtl/esdp_back.sv @@
// Back end of the parser: turns queued events into result items on the output register.
// An event with an element and a verdict is sent as two items, element first.
// Depends on esdp_pkg.
module esdp_back import esdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  esdp_evt_t head,
	input  logic      head_valid,
	output logic      pop,
	output logic      result_valid,
	output out_item_t result,
	input  logic      result_stall
);

	logic      valid_q, elem_done_q, load, send_elem;
	out_item_t result_q, verdict_item;

	assign load      = head_valid && (!valid_q || !result_stall);
	assign send_elem = head.has_elem && !elem_done_q;
	assign pop       = load && !(send_elem && head.has_verdict);

	always_comb begin
		verdict_item             = '0;
		verdict_item.result_kind = head.verdict;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= send_elem ? head.elem : verdict_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			elem_done_q <= 1'b0;
		end else begin
			if (!valid_q || !result_stall) begin
				valid_q <= head_valid;
			end
			if (load) begin
				elem_done_q <= send_elem && head.has_verdict;
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

	a_split_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		elem_done_q |-> (head_valid && head.has_elem && head.has_verdict))
		else $error("split event lost its queue entry");

	a_verdict_after_element: assert property (@(posedge clk) disable iff (!arst_n)
		(load && send_elem && head.has_verdict) |=> elem_done_q)
		else $error("verdict of a split event not kept for a second item");

	a_load_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not presented");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for element_status_descriptor_parser_top: random READ ELEMENT STATUS
// responses, a cycle-free predictor of the parser, and a scoreboard with bursty handshakes.
// Depends on esdp_pkg and the parser RTL.
module tb;
	import esdp_pkg::*;

	localparam int POS_BITS = 12;
	localparam int unsigned POS_MAX = (1 << POS_BITS) - 1;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	in_item_t item = '0;
	logic item_stall;
	logic result_valid;
	out_item_t result;
	logic result_stall = 1'b0;

	in_item_t pending_bytes[$];
	out_item_t predicted_results[$];
	out_item_t want_result;

	logic idle_on = 1'b1;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int unsigned long_hold_left = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int bytes_queued = 0;
	int responses_queued = 0;
	int bytes_accepted = 0;
	int elements_checked = 0;
	int verdicts_checked = 0;
	int mismatch_count = 0;

	// Parser state as the predictor tracks it.
	int unsigned byte_pos;
	int unsigned resp_end;
	int unsigned page_limit;
	logic [7:0] page_type_code;
	logic [15:0] desc_len;
	int unsigned desc_base;
	logic [7:0] hdr [8];
	logic [7:0] desc [DESC_BYTES];
	phase_t phase;
	logic emitted_any;

	element_status_descriptor_parser_top #(
		.POSITION_BITS(POS_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item(item),
		.item_stall(item_stall),
		.result_valid(result_valid),
		.result(result),
		.result_stall(result_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_parser();
		byte_pos = 0;
		resp_end = 0;
		page_limit = 0;
		page_type_code = '0;
		desc_len = '0;
		desc_base = 0;
		for (int i = 0; i < 8; i++) hdr[i] = '0;
		for (int i = 0; i < DESC_BYTES; i++) desc[i] = '0;
		phase = PH_HEADER;
		emitted_any = 1'b0;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic last);
		int unsigned idx;
		int unsigned k;
		int unsigned count;
		int unsigned page_stop;
		out_item_t r;
		idx = byte_pos;
		if (byte_pos < POS_MAX) byte_pos++;
		if (idx < POS_MAX) begin
			if (phase == PH_HEADER) begin
				hdr[idx[2:0]] = b;
				if (idx >= HEADER_LAST) begin
					count = {hdr[5], hdr[6], hdr[7]} + 8;
					resp_end = count > POS_MAX ? POS_MAX : count;
					desc_base = 8;
					phase = PH_PAGE;
				end
			end else if (idx < resp_end) begin
				if (phase != PH_PAGE && idx >= page_limit) begin
					phase = PH_PAGE;
					desc_base = idx;
				end
				k = idx - desc_base;
				if (phase == PH_PAGE) begin
					hdr[k[2:0]] = b;
					if (k >= HEADER_LAST) begin
						page_stop = desc_base + 8 + {hdr[5], hdr[6], hdr[7]};
						page_type_code = hdr[0];
						desc_len = {hdr[2], hdr[3]};
						page_limit = page_stop < resp_end ? page_stop : resp_end;
						desc_base = idx + 1;
						phase = desc_len >= DESC_MIN ? PH_DESC : PH_SKIP;
					end
				end else if (phase == PH_DESC) begin
					if (k < DESC_BYTES) desc[k[3:0]] = b;
					if (k + 1 == desc_len) begin
						r = '0;
						r.result_kind = RK_ELEMENT;
						r.elem_type = page_type_code;
						r.elem_addr = {desc[0], desc[1]};
						r.status_flags = desc[2][5:0];
						r.sense_code = desc[4];
						r.sense_qualifier = desc[5];
						r.logical_unit = desc[6][2:0];
						r.bus_flags = {desc[6][7], desc[6][5], desc[6][4]};
						r.target_id = desc[7];
						r.source_flags = {desc[9][7], desc[9][6]};
						r.source_address = {desc[10], desc[11]};
						predicted_results.insert(predicted_results.size(), r);
						emitted_any = 1'b1;
						desc_base = idx + 1;
					end
				end
			end
		end
		if (last) begin
			count = byte_pos < resp_end ? byte_pos : resp_end;
			r = '0;
			if (byte_pos < 8) r.result_kind = RK_FAILURE;
			else if (emitted_any || count == 8) r.result_kind = RK_SUCCESS;
			else r.result_kind = RK_FAILURE;
			predicted_results.insert(predicted_results.size(), r);
			clear_parser();
		end
	endfunction

	function automatic string show_result(input out_item_t r);
		return $sformatf({"kind=%0d type=%h addr=%h flags=%h asc=%h ascq=%h lun=%0d bus=%0d ",
			"id=%h src_flags=%0d src=%h"}, r.result_kind, r.elem_type, r.elem_addr,
			r.status_flags, r.sense_code, r.sense_qualifier, r.logical_unit, r.bus_flags,
			r.target_id, r.source_flags, r.source_address);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		it.data_byte = b;
		it.end_of_buffer = last;
		pending_bytes.insert(pending_bytes.size(), it);
		bytes_queued++;
		if (last) responses_queued++;
	endtask

	// Shape 0 is a random response and shape 1 is dense with short descriptors.
	task automatic queue_response(input int shape);
		logic [7:0] bytes_q[$];
		logic [23:0] count_field;
		logic [23:0] pbc_field;
		logic [15:0] dlen;
		int pages;
		int ndesc;
		int body;
		int len;
		int p;
		bytes_q = {};
		if (shape == 0 && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 40)) bytes_q.insert(bytes_q.size(), rand_byte());
		end else begin
			repeat (8) bytes_q.insert(bytes_q.size(), rand_byte());
			pages = shape == 1 ? 2 : $urandom_range(0, 3);
			for (p = 0; p < pages; p++) begin
				if (shape == 1) begin
					dlen = 16'd12;
					ndesc = 4;
				end else begin
					case ($urandom_range(0, 9))
						0: dlen = 16'($urandom_range(0, 11));
						1: dlen = 16'($urandom_range(25, 70));
						2: dlen = 16'($urandom_range(0, 65535));
						default: dlen = 16'($urandom_range(12, 24));
					endcase
					ndesc = dlen > 70 ? 0 : $urandom_range(0, 4);
				end
				body = dlen * ndesc;
				if (shape == 0 && dlen < 12) body = $urandom_range(0, 30);
				if (shape == 0 && $urandom_range(0, 5) == 0) body += $urandom_range(1, 11);
				pbc_field = 24'(body);
				if (shape == 0) begin
					case ($urandom_range(0, 9))
						0: if (body > 0) pbc_field = 24'(body - $urandom_range(1, body));
						1: pbc_field = 24'(body + $urandom_range(1, 40));
						2: pbc_field = 24'($urandom_range(0, 24'hFFFFFF));
						default: ;
					endcase
				end
				bytes_q.insert(bytes_q.size(), rand_byte());
				bytes_q.insert(bytes_q.size(), rand_byte());
				bytes_q.insert(bytes_q.size(), dlen[15:8]);
				bytes_q.insert(bytes_q.size(), dlen[7:0]);
				bytes_q.insert(bytes_q.size(), rand_byte());
				bytes_q.insert(bytes_q.size(), pbc_field[23:16]);
				bytes_q.insert(bytes_q.size(), pbc_field[15:8]);
				bytes_q.insert(bytes_q.size(), pbc_field[7:0]);
				repeat (body) bytes_q.insert(bytes_q.size(), rand_byte());
			end
			count_field = 24'(bytes_q.size() - 8);
			if (shape == 0) begin
				case ($urandom_range(0, 9))
					0: count_field = 24'($urandom_range(0, bytes_q.size()));
					1: count_field = 24'($urandom_range(0, 24'hFFFFFF));
					2: count_field = 24'(bytes_q.size() - 8 + $urandom_range(1, 20));
					default: ;
				endcase
			end
			bytes_q[5] = count_field[23:16];
			bytes_q[6] = count_field[15:8];
			bytes_q[7] = count_field[7:0];
		end
		len = bytes_q.size();
		if (shape == 0) begin
			case ($urandom_range(0, 7))
				0: len = $urandom_range(1, bytes_q.size());
				1: begin
					repeat ($urandom_range(1, 10)) bytes_q.insert(bytes_q.size(), rand_byte());
					len = bytes_q.size();
				end
				default: ;
			endcase
		end
		for (p = 0; p < len; p++) queue_byte(bytes_q[p], p == len - 1);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || item_valid || predicted_results.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				parse_byte(item.data_byte, item.end_of_buffer);
				bytes_accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_bytes.size() == 0) begin
					item_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 11);
					item_valid <= 1'b0;
				end else begin
					item <= pending_bytes.pop_front();
					item_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			long_hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (long_hold_left != 0) begin
			long_hold_left <= long_hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Unexpected result with nothing pending: %s", show_result(result));
				end else begin
					want_result = predicted_results.pop_front();
					if (want_result.result_kind == RK_ELEMENT) elements_checked++;
					else verdicts_checked++;
					if (result.result_kind !== want_result.result_kind ||
							result.elem_type !== want_result.elem_type ||
							result.elem_addr !== want_result.elem_addr ||
							result.status_flags !== want_result.status_flags ||
							result.sense_code !== want_result.sense_code ||
							result.sense_qualifier !== want_result.sense_qualifier ||
							result.logical_unit !== want_result.logical_unit ||
							result.bus_flags !== want_result.bus_flags ||
							result.target_id !== want_result.target_id ||
							result.source_flags !== want_result.source_flags ||
							result.source_address !== want_result.source_address) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("Mismatch expected: %s", show_result(want_result));
							$display("         actual:   %s", show_result(result));
						end
					end
				end
			end
			if (long_hold_left != 0) begin
				result_stall <= 1'b1;
			end else if (recv_gap != 0) begin
				recv_gap--;
				result_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 11);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Too short for a header, a bare header of zero count, and one all-ones element.
		queue_byte(8'hFF, 1'b1);
		repeat (7) queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		repeat (7) queue_byte(8'h00, 1'b0);
		queue_byte(8'h14, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h0C, 1'b0);
		repeat (3) queue_byte(8'h00, 1'b0);
		queue_byte(8'h0C, 1'b0);
		repeat (11) queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_drained();

		// The receiver holds off while dense responses keep coming.
		hold_req <= 1'b1;
		repeat (4) queue_response(1);
		wait_drained();

		while (bytes_queued < 1600) queue_response(0);
		wait_drained();

		idle_on <= 1'b0;
		while (bytes_queued < 2000) queue_response(0);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Checked %0d element results and %0d verdicts over %0d responses (%0d bytes),",
			elements_checked, verdicts_checked, responses_queued, bytes_accepted);
		$display("including short, truncated and oversized responses and a long receiver hold.");
		if (mismatch_count == 0 && predicted_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count,
				predicted_results.size());
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("Timed out with %0d results outstanding", predicted_results.size());
		$display("simulation failed");
		$finish;
	end

endmodule

@@ element_status_descriptor_parser_top.f @@
rtl/esdp_pkg.sv
rtl/esdp_front.sv
rtl/esdp_queue.sv
rtl/esdp_back.sv
rtl/element_status_descriptor_parser_top.sv
bench/tb.sv
